/* hdl/signed_int_to_decimal_ascii_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII unit
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge out of reset.
`define SIDA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sida assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sida assertion failed");

`else

`define SIDA_ASSERT(lbl, clk, rstn, prop)
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hdl/sida_pkg.sv */
// ---------------------------------------------------------------------------
// sida_pkg
// Shared constants and command/status types of the decimal ASCII unit.
// ---------------------------------------------------------------------------
package sida_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int PROD_W      = 2 * VALUE_BITS;
  // floor(x * RECIP / 2^RECIP_SHIFT) == x / 10 for every x below 2^VALUE_BITS
  localparam int RECIP_SHIFT = VALUE_BITS + 3;
  localparam logic [VALUE_BITS-1:0] RECIP = 32'hCCCC_CCCD;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  typedef struct packed {
    logic load;       // capture a new request
    logic mul;        // multiply magnitude by reciprocal
    logic div;        // split off one digit
    logic out_sign;   // load the minus sign into the output register
    logic out_digit;  // load the next stored digit into the output register
  } sida_cmd_t;

  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic cnt_one;
    logic cnt_zero;
  } sida_sts_t;

endpackage

/* hdl/sida_dp.sv */
// ---------------------------------------------------------------------------
// sida_dp
// Datapath: magnitude, divide-by-ten multiplier, digit buffer, output char.
// ---------------------------------------------------------------------------
module sida_dp
  import sida_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  sida_cmd_t                    cmd_i,
  output sida_sts_t                    sts_o,
  output logic        [CHAR_W-1:0]     text_char_o,
  output logic                         last_o
);

  logic [VALUE_BITS-1:0] mag_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIGIT_W-1:0]    dig_q [MAX_DIGITS];
  logic [CHAR_W-1:0]     text_char_q;
  logic                  last_q;

  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] rem;
  logic [CNT_W-1:0]      cnt_dec;
  logic [DIG_IDX_W-1:0]  wr_idx;
  logic [DIG_IDX_W-1:0]  rd_idx;

  always_comb begin
    value_u = VALUE_BITS'(value_i);
    mag_in  = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
    quot    = VALUE_BITS'(prod_q >> RECIP_SHIFT);
    rem     = mag_q - ((quot << 3) + (quot << 1));
    cnt_dec = cnt_q - CNT_W'(1);
    wr_idx  = cnt_q[DIG_IDX_W-1:0];
    rd_idx  = cnt_dec[DIG_IDX_W-1:0];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.div) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.out_digit) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_in;
      neg_q <= value_u[VALUE_BITS-1];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
    end
    if (cmd_i.div) begin
      mag_q         <= quot;
      dig_q[wr_idx] <= rem[DIGIT_W-1:0];
    end
    if (cmd_i.out_sign) begin
      text_char_q <= CH_MINUS;
      last_q      <= 1'b0;
    end else if (cmd_i.out_digit) begin
      text_char_q <= CH_ZERO + CHAR_W'(dig_q[rd_idx]);
      last_q      <= (cnt_q == CNT_W'(1));
    end
  end

  assign sts_o.neg       = neg_q;
  assign sts_o.quot_zero = (quot == '0);
  assign sts_o.cnt_one   = (cnt_q == CNT_W'(1));
  assign sts_o.cnt_zero  = (cnt_q == '0);

  assign text_char_o = text_char_q;
  assign last_o      = last_q;

endmodule

/* hdl/sida_ctrl.sv */
// ---------------------------------------------------------------------------
// sida_ctrl
// Controller: sequences digit extraction and character output handshake.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sida_ctrl
  import sida_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sida_sts_t sts_i,
  output sida_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.quot_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          cmd_o.out_sign = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_digit = 1'b1;
          out_valid_d     = 1'b1;
          // last stored digit leaves: take the next request
          if (sts_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `SIDA_ASSERT_NEXT(a_accept_to_mul, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_MUL)
  `SIDA_ASSERT(a_emit_has_digit, clk_i, rst_ni, (state_q == ST_EMIT) |-> !sts_i.cnt_zero)
  `SIDA_ASSERT(a_load_only_free, clk_i, rst_ni, (cmd_o.out_sign || cmd_o.out_digit) |-> out_free)
  `SIDA_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0({cmd_o.load, cmd_o.mul, cmd_o.div, cmd_o.out_sign, cmd_o.out_digit}))

endmodule

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// A new request is accepted only once the last character of the previous one has
// been loaded into the output register. Each digit passes through the MUL and DIV
// states of the shared divide-by-ten multiply and subtract; characters then leave,
// a minus sign first if negative, one per cycle from the digit buffer while not stalled.
// Reset clears the controller state, the output valid and the digit count.
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Prints a signed integer as decimal ASCII characters, one per output request.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
  import sida_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [CHAR_W-1:0]     text_char_o,
  output logic                         last_o
);

  sida_cmd_t cmd;
  sida_sts_t sts;

  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sida_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

endmodule
